### rtl/enf_pkg.sv
// Shared constants, register codes and control types for the enveloped noise block.
`timescale 1ns / 1ps
package enf_pkg;

  // Sample index and clip length widths
  localparam int IDX_W  = 16;
  localparam int CLIP_W = 16;
  localparam int CMP_W  = ((IDX_W > CLIP_W) ? IDX_W : CLIP_W) + 1;

  // Lowpass coefficient fraction bits and the width of the filter sum
  localparam int COEF_FRAC  = 16;
  localparam int FILT_SUM_W = (COEF_FRAC < 16) ? (37 - COEF_FRAC) : 21;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Noise generator
  localparam logic [31:0] LCG_MUL     = 32'd1664525;
  localparam logic [31:0] LCG_ADD     = 32'd1013904223;
  localparam logic [31:0] NOISE_RESET = 32'h2545F491;

  // Envelope and output scaling
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam int          OUT_FULL = 32000;

  // Configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LENGTH  = 3'd0,
    CFG_CUTOFF_COEF  = 3'd1,
    CFG_DECAY_RATIO  = 3'd2,
    CFG_GAIN         = 3'd3,
    CFG_ATTACK_STEP  = 3'd4,
    CFG_OVERLAY_MODE = 3'd5,
    CFG_NOISE_SEED   = 3'd6
  } cfg_idx_t;

  // Step commands from the controller, at most one high per cycle
  typedef struct packed {
    logic noise;
    logic filt;
    logic modul;
    logic scale;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic out_stall;
  } stat_t;

endpackage

### rtl/enf_ctrl.sv
// Step sequencer for the enveloped noise block: one item through four steps.
`timescale 1ns / 1ps
module enf_ctrl
  import enf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FILT  = 4'b0010,
    ST_MOD   = 4'b0100,
    ST_SCALE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Take an item only between items
  assign in_tready = (state_r == ST_IDLE);

  // Advance through the steps; hold the last step while the output register holds an item that is not taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_FILT;
      ST_FILT:  state_nxt = ST_MOD;
      ST_MOD:   state_nxt = ST_SCALE;
      ST_SCALE: if (!stat.out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Issue the step commands
  always_comb begin
    cmd.noise = (state_r == ST_IDLE) && in_tvalid;
    cmd.filt  = (state_r == ST_FILT);
    cmd.modul = (state_r == ST_MOD);
    cmd.scale = (state_r == ST_SCALE) && !stat.out_stall;
  end

endmodule

### rtl/enf_dp.sv
// Datapath: noise generator, lowpass, envelope, gain scaling and output register.
`timescale 1ns / 1ps
module enf_dp
  import enf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]           in_tdata,
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,
  output logic                  out_tlast
);

  localparam logic signed [17:0] LEVEL_MAX = 18'sd131071;
  localparam logic signed [17:0] LEVEL_MIN = -18'sd131072;
  localparam logic signed [19:0] OUT_MAX   = 20'(OUT_FULL);
  localparam logic signed [19:0] OUT_MIN   = -20'(OUT_FULL);

  // Configuration registers
  logic [CLIP_W-1:0] clip_length_r;
  logic [15:0]       cutoff_coef_r;
  logic [15:0]       decay_ratio_r;
  logic [16:0]       gain_r;
  logic [16:0]       attack_step_r;
  logic              overlay_mode_r;
  logic [31:0]       noise_seed_r;

  // Block state
  logic [31:0]        noise_r;
  logic signed [17:0] level_r;
  logic [IDX_W-1:0]   index_r;
  logic [16:0]        decay_r;
  logic [16:0]        attack_r;

  // Per-item working registers
  logic signed [15:0] existing_r;
  logic [16:0]        env_r;
  logic [16:0]        decay_new_r;
  logic [31:0]        gk_r;
  logic signed [17:0] m_r;

  // Output register
  logic               out_valid_r;
  logic [15:0]        out_data_r;
  logic               out_last_r;

  // Shared multipliers
  logic signed [32:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [54:0] mul_p;
  logic [16:0]        aux_a;
  logic [16:0]        aux_b;
  logic [33:0]        aux_p;

  logic [31:0]             lcg_src;
  logic signed [15:0]      noise_q;
  logic signed [18:0]      diff;
  logic signed [FILT_SUM_W-1:0] filt_step;
  logic signed [FILT_SUM_W-1:0] filt_sum;
  logic signed [17:0]      level_sat;
  logic signed [54:0]      m_full;
  logic signed [54:0]      s_full;
  logic signed [18:0]      s_val;
  logic signed [19:0]      mix;
  logic signed [19:0]      mix_sat;

  logic [CLIP_W-1:0] len_eff;
  logic [IDX_W:0]    idx_inc;
  logic              last;
  logic [17:0]       attack_sum;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_length_r  <= CLIP_W'(1);
      cutoff_coef_r  <= '0;
      decay_ratio_r  <= 16'hFFFF;
      gain_r         <= '0;
      attack_step_r  <= ONE_Q16;
      overlay_mode_r <= 1'b0;
      noise_seed_r   <= NOISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP_LENGTH:  clip_length_r  <= cfg_wdata[CLIP_W-1:0];
        CFG_CUTOFF_COEF:  cutoff_coef_r  <= cfg_wdata[15:0];
        CFG_DECAY_RATIO:  decay_ratio_r  <= cfg_wdata[15:0];
        CFG_GAIN:         gain_r         <= cfg_wdata[16:0];
        CFG_ATTACK_STEP:  attack_step_r  <= cfg_wdata[16:0];
        CFG_OVERLAY_MODE: overlay_mode_r <= cfg_wdata[0];
        CFG_NOISE_SEED:   noise_seed_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Reseed takes effect before this item's generator step
  assign lcg_src = in_tuser ? noise_seed_r : noise_r;

  // Noise value: bits 23..8 minus 32768, i.e. the same bits with the top one flipped
  assign noise_q = $signed({~noise_r[23], noise_r[22:8]});
  assign diff    = 19'(noise_q) - 19'(level_r);

  // Select operands of the main multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd.noise) begin
      mul_a = $signed({1'b0, lcg_src});
      mul_b = $signed(LCG_MUL[21:0]);
    end else if (cmd.filt) begin
      mul_a = 33'(diff);
      mul_b = $signed({6'd0, cutoff_coef_r});
    end else if (cmd.modul) begin
      mul_a = 33'(level_r);
      mul_b = $signed({5'd0, env_r});
    end else if (cmd.scale) begin
      mul_a = $signed({1'b0, gk_r});
      mul_b = 22'(m_r);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Select operands of the envelope multiplier
  always_comb begin
    aux_a = '0;
    aux_b = '0;
    priority if (cmd.noise) begin
      aux_a = attack_r;
      aux_b = decay_r;
    end else if (cmd.filt) begin
      aux_a = decay_r;
      aux_b = {1'b0, decay_ratio_r};
    end else if (cmd.modul) begin
      aux_a = gain_r;
      aux_b = 17'(OUT_FULL);
    end
  end

  assign aux_p = aux_a * aux_b;

  // Lowpass step: floor shift of the product, then saturate
  assign filt_step = FILT_SUM_W'(mul_p >>> COEF_FRAC);
  assign filt_sum  = FILT_SUM_W'(level_r) + filt_step;

  always_comb begin
    priority if (filt_sum > FILT_SUM_W'(LEVEL_MAX)) level_sat = LEVEL_MAX;
    else if (filt_sum < FILT_SUM_W'(LEVEL_MIN))     level_sat = LEVEL_MIN;
    else                                            level_sat = filt_sum[17:0];
  end

  // Truncate toward zero: bias negative products before the arithmetic shift
  assign m_full = (mul_p + (mul_p[54] ? 55'sd65535 : 55'sd0)) >>> 16;
  assign s_full = (mul_p + (mul_p[54] ? 55'sd2147483647 : 55'sd0)) >>> 31;
  assign s_val  = s_full[18:0];

  // Mix with the incoming sample and clamp
  assign mix = overlay_mode_r ? (20'(existing_r) + 20'(s_val)) : 20'(s_val);

  always_comb begin
    priority if (mix > OUT_MAX) mix_sat = OUT_MAX;
    else if (mix < OUT_MIN)     mix_sat = OUT_MIN;
    else                        mix_sat = mix;
  end

  // End of clip: zero length acts as one
  assign len_eff    = (clip_length_r == '0) ? CLIP_W'(1) : clip_length_r;
  assign idx_inc    = {1'b0, index_r} + (IDX_W+1)'(1);
  assign last       = CMP_W'(idx_inc) >= CMP_W'(len_eff);
  assign attack_sum = {1'b0, attack_r} + {1'b0, attack_step_r};

  // Block state and per-item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r  <= NOISE_RESET;
      level_r  <= '0;
      index_r  <= '0;
      decay_r  <= ONE_Q16;
      attack_r <= '0;
    end else begin
      if (cmd.noise) begin
        noise_r <= mul_p[31:0] + LCG_ADD;
      end
      if (cmd.filt) begin
        level_r <= level_sat;
      end
      if (cmd.scale) begin
        if (last) begin
          index_r  <= '0;
          level_r  <= '0;
          decay_r  <= ONE_Q16;
          attack_r <= '0;
        end else begin
          index_r  <= idx_inc[IDX_W-1:0];
          decay_r  <= decay_new_r;
          attack_r <= (attack_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : attack_sum[16:0];
        end
      end
    end
  end

  // Working registers carry payload only
  always_ff @(posedge clk) begin
    if (cmd.noise) begin
      existing_r <= $signed(in_tdata);
      env_r      <= aux_p[32:16];
    end
    if (cmd.filt) begin
      decay_new_r <= aux_p[32:16];
    end
    if (cmd.modul) begin
      m_r  <= m_full[17:0];
      gk_r <= aux_p[31:0];
    end
    if (cmd.scale) begin
      out_data_r <= mix_sat[15:0];
      out_last_r <= last;
    end
  end

  // Output register: fill on the final step, drain on handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (cmd.scale) out_valid_r <= 1'b1;
      else if (out_tready)    out_valid_r <= 1'b0;
    end
  end

  assign stat.out_stall = out_valid_r && !out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign out_tlast      = out_last_r;

endmodule

### rtl/enveloped_filtered_noise.sv
// Top level of the enveloped filtered noise source.
`timescale 1ns / 1ps
// Each accepted input item is one sample tick and yields exactly one output item: LCG noise,
// one-pole lowpass, attack/decay envelope and gain, either as a fresh sample or added onto
// in_tdata (overlay mode), clamped to +-32000; out_tlast marks the final sample of a clip.
// The accept cycle steps the noise generator and forms the envelope; the lowpass, envelope
// product and gain scaling then follow in turn, each as a separate step on the shared
// 33x22 multiplier, which is the chain that sets the rate. The last step waits while the
// output register still holds an item that has not been taken. No clearing pass after reset.
// Write configuration only between items.
module enveloped_filtered_noise
  import enf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] existing_sample
  input  logic                  in_tuser,   // [0] reseed
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] sample
  output logic                  out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  enf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  enf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/enf_chk.sv
// Port-level checks for the enveloped noise block and their bind to the top level.
`timescale 1ns / 1ps
module enf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // Keep every output sample inside the clamp range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= 16'sd32000) && ($signed(out_tdata) >= -16'sd32000))
    else $error("output sample outside clamp range");

  // Drop ready while an accepted item is in work
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during item work");

  // Present a valid output once an accepted item has passed its steps
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##4 out_tvalid)
    else $error("no result after accepted item");

endmodule

bind enveloped_filtered_noise enf_chk u_enf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### sim/enveloped_filtered_noise_tb.sv
// Self-checking testbench for the enveloped filtered noise source: predicts every sample.
`timescale 1ns / 1ps
module enveloped_filtered_noise_tb;
  import enf_pkg::*;

  typedef struct packed {
    logic [15:0] smp;
    logic        is_last;
  } clip_sample_t;

  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SEND_IDLE,
    TRAFFIC_RECV_STALL,
    TRAFFIC_BOTH
  } traffic_t;

  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 94;
  localparam int LONG_HOLD = 300;

  // Tracks generator, filter and envelope state and queues the samples they produce
  class sample_scoreboard;
    logic [15:0] clip_length, cutoff_coef, decay_ratio;
    logic [16:0] gain, attack_step;
    logic        overlay_mode;
    logic [31:0] noise_seed;
    logic [31:0] lcg;
    longint      filt_level;
    logic [15:0] tick_index;
    logic [16:0] decay_lvl, attack_lvl;
    clip_sample_t expected_samples[$];
    int mismatches;

    function new();
      clip_length  = 16'd1;
      cutoff_coef  = 16'd0;
      decay_ratio  = 16'hFFFF;
      gain         = 17'd0;
      attack_step  = ONE_Q16;
      overlay_mode = 1'b0;
      noise_seed   = NOISE_RESET;
      lcg          = NOISE_RESET;
      filt_level   = 0;
      tick_index   = 16'd0;
      decay_lvl    = ONE_Q16;
      attack_lvl   = 17'd0;
      mismatches   = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_CLIP_LENGTH:  clip_length  = val[15:0];
        CFG_CUTOFF_COEF:  cutoff_coef  = val[15:0];
        CFG_DECAY_RATIO:  decay_ratio  = val[15:0];
        CFG_GAIN:         gain         = val[16:0];
        CFG_ATTACK_STEP:  attack_step  = val[16:0];
        CFG_OVERLAY_MODE: overlay_mode = val[0];
        CFG_NOISE_SEED:   noise_seed   = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // Step the generator, filter and envelope for one accepted tick
    function void note_tick(logic [15:0] existing, logic reseed);
      longint noise, lvl, env, m, s, r, nxt;
      logic [31:0] clip_len;
      clip_sample_t res;
      if (reseed) lcg = noise_seed;
      lcg = lcg * LCG_MUL + LCG_ADD;
      noise = longint'(lcg[23:8]) - 32768;

      // one-pole lowpass, floor rounding, saturate to 18 bits
      lvl = filt_level;
      lvl = lvl + (((noise - lvl) * longint'(cutoff_coef)) >>> COEF_FRAC);
      if (lvl > 131071) lvl = 131071;
      if (lvl < -131072) lvl = -131072;
      filt_level = lvl;

      // envelope and gain, both products truncated toward zero
      env = (longint'(attack_lvl) * longint'(decay_lvl)) >> 16;
      m = lvl * env;
      m = (m < 0) ? -((-m) >>> 16) : (m >>> 16);
      s = m * longint'(gain) * OUT_FULL;
      s = (s < 0) ? -((-s) >>> 31) : (s >>> 31);

      r = overlay_mode ? longint'($signed(existing)) + s : s;
      if (r > OUT_FULL) r = OUT_FULL;
      if (r < -OUT_FULL) r = -OUT_FULL;

      // a zero clip length behaves as one
      clip_len = (clip_length == 16'd0) ? 32'd1 : {16'd0, clip_length};
      res.smp = r[15:0];
      res.is_last = ({16'd0, tick_index} + 32'd1 >= clip_len);
      if (res.is_last) begin
        tick_index = 16'd0;
        filt_level = 0;
        decay_lvl  = ONE_Q16;
        attack_lvl = 17'd0;
      end else begin
        tick_index = tick_index + 16'd1;
        nxt = longint'(attack_lvl) + longint'(attack_step);
        attack_lvl = (nxt > 65536) ? ONE_Q16 : nxt[16:0];
        nxt = (longint'(decay_lvl) * longint'(decay_ratio)) >> 16;
        decay_lvl = nxt[16:0];
      end
      expected_samples.push_back(res);
    endfunction

    // Compare one output item against the oldest prediction
    function void check_sample(logic [15:0] smp, logic is_last);
      clip_sample_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output sample %0d last %0b", $signed(smp), is_last);
        return;
      end
      want = expected_samples.pop_front();
      if (want.smp !== smp || want.is_last !== is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: sample expected %0d last %0b, got %0d last %0b",
                   $signed(want.smp), want.is_last, $signed(smp), is_last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = 16'd0;   // [15:0] existing_sample
  logic                  in_tuser = 1'b0;    // [0] reseed
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;          // [15:0] sample
  logic                  out_tlast;

  sample_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;

  enveloped_filtered_noise uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("enveloped_filtered_noise_tb: errors");
    $finish;
  end

  // Receive side: check accepted items, then pick the next ready level
  always @(posedge clk) begin
    int unsigned hold_seen;
    int unsigned hold_left;
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata, out_tlast);
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_FREE:       begin send_idle_pct = 0;  stall_pct = 0;  end
      TRAFFIC_SEND_IDLE:  begin send_idle_pct = 57; stall_pct = 0;  end
      TRAFFIC_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 57; end
      default:            begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  // Offer one tick, with random idle cycles ahead of it, and hold until taken
  task automatic send_tick(input logic [15:0] existing, input logic reseed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= existing;
    in_tuser  <= reseed;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(existing, reseed);
  endtask

  // Stop offering and wait for every predicted sample to come out
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_setting();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'd0;
      1: v = 32'd65535;
      2: v = $urandom_range(16'hFFFF);
      default: v = $urandom_range(48, 1);
    endcase
    cfg_write(CFG_CLIP_LENGTH, v);
    case ($urandom_range(5))
      0: v = 32'd0;
      1: v = 32'd65535;
      default: v = $urandom_range(16'hFFFF);
    endcase
    cfg_write(CFG_CUTOFF_COEF, v);
    case ($urandom_range(5))
      0: v = 32'd0;
      1: v = 32'd65535;
      default: v = $urandom_range(65535, 50000);
    endcase
    cfg_write(CFG_DECAY_RATIO, v);
    case ($urandom_range(5))
      0: v = 32'd0;
      1: v = 32'd131071;
      default: v = $urandom_range(17'h1FFFF);
    endcase
    cfg_write(CFG_GAIN, v);
    case ($urandom_range(5))
      0: v = 32'd0;
      1: v = 32'd65536;
      2: v = $urandom_range(17'h1FFFF);
      default: v = $urandom_range(65536, 1);
    endcase
    cfg_write(CFG_ATTACK_STEP, v);
    cfg_write(CFG_OVERLAY_MODE, $urandom_range(1));
    cfg_write(CFG_NOISE_SEED, $urandom());
  endtask

  initial begin
    int unsigned phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full gain, saturating attack, extreme incoming samples, reseeds
    set_traffic(TRAFFIC_FREE);
    cfg_write(CFG_CLIP_LENGTH, 32'd3);
    cfg_write(CFG_CUTOFF_COEF, 32'd65535);
    cfg_write(CFG_DECAY_RATIO, 32'd65535);
    cfg_write(CFG_GAIN, 32'd131071);
    cfg_write(CFG_ATTACK_STEP, 32'd131071);
    cfg_write(CFG_NOISE_SEED, 32'h0000_0000);
    send_tick(16'h7FFF, 1'b1);
    send_tick(16'h8000, 1'b0);
    send_tick(16'h0000, 1'b0);
    send_tick(16'hFFFF, 1'b1);
    send_tick(16'h7FFF, 1'b0);
    send_tick(16'h8000, 1'b0);
    wait_drain();

    // Directed: overlay with every sample last, from a ceiling seed
    cfg_write(CFG_OVERLAY_MODE, 32'd1);
    cfg_write(CFG_CLIP_LENGTH, 32'd0);
    cfg_write(CFG_NOISE_SEED, 32'hFFFF_FFFF);
    send_tick(16'h7FFF, 1'b1);
    send_tick(16'h8000, 1'b0);
    send_tick(16'h8301, 1'b0);
    send_tick(16'h7CFF, 1'b0);
    send_tick(16'h0001, 1'b1);
    wait_drain();

    // Directed: zero coefficients over a long clip, then shorten it mid-clip
    cfg_write(CFG_CLIP_LENGTH, 32'd65535);
    cfg_write(CFG_CUTOFF_COEF, 32'd0);
    cfg_write(CFG_DECAY_RATIO, 32'd0);
    cfg_write(CFG_GAIN, 32'd0);
    cfg_write(CFG_ATTACK_STEP, 32'd0);
    send_tick(16'h1234, 1'b0);
    send_tick(16'hEDCB, 1'b0);
    send_tick(16'h8000, 1'b0);
    send_tick(16'h7FFF, 1'b0);
    wait_drain();
    cfg_write(CFG_CLIP_LENGTH, 32'd2);
    cfg_write(CFG_OVERLAY_MODE, 32'd0);
    cfg_write(CFG_CUTOFF_COEF, 32'd40000);
    cfg_write(CFG_GAIN, 32'd65536);
    cfg_write(CFG_ATTACK_STEP, 32'd65536);
    cfg_write(CFG_DECAY_RATIO, 32'd65535);
    send_tick(16'h0000, 1'b0);
    send_tick(16'h0000, 1'b0);
    send_tick(16'h0000, 1'b0);
    send_tick(16'h0000, 1'b0);
    wait_drain();

    // Random phases: new setting each time, traffic shape rotates
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_setting();
      set_traffic(traffic_t'(phase % 4));
      // fill the block against a stalled receiver
      if (phase == 0 || phase == 4) hold_requests++;
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        // pause the sender until everything is out, then carry on
        if (phase == 5 && i == TICKS_PER_PHASE / 2) wait_drain();
        send_tick(16'($urandom_range(16'hFFFF)), ($urandom_range(19) == 0));
      end
      wait_drain();
    end

    repeat (16) @(posedge clk);
    if (sb.pending() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("enveloped_filtered_noise_tb: clean");
    end else begin
      $display("enveloped_filtered_noise_tb: errors");
    end
    $finish;
  end

endmodule
